// File: rtl/rlgf_pkg.sv
// ---------------------------------------------------------------------------
// rlgf_pkg: shared types and constants
// Field widths, fixed-point layout and sequencer states of the gradient fill.
// ---------------------------------------------------------------------------
package rlgf_pkg;

    localparam int IDX_W           = 6;
    localparam int COL_W           = 8;
    localparam int FRAC_SHIFT      = 7;
    localparam int ACC_W           = 16;
    localparam int NUM_CH          = 3;
    localparam int DIV_STEPS       = COL_W + FRAC_SHIFT;   // quotient bits
    localparam int IN_DATA_W       = 64;
    localparam int OUT_DATA_W      = 32;
    localparam int PIXEL_COUNT_DEF = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/rgb_linear_gradient_fill.sv
// ---------------------------------------------------------------------------
// rgb_linear_gradient_fill: RGB linear gradient over a pixel run
// Sorts the two ends, computes a signed 8.7 step per channel with one shared
// restoring divider, then walks 8.8 accumulators one pixel per transfer.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                                   | side band
//  s_*     | in  | both ends: index and RGB of each        | -
//  m_*     | out | pixel index and RGB                     | tlast = last pixel
//
//  Each item is set up channel by channel (one load plus 15 steps of the shared
//  divider), then emits one pixel per cycle while the output is not stalled.
//  Reset (rst_n low, asynchronous) returns to idle with no pending output.
//  A stall on m_tready holds the current pixel; s_tready is high only in idle.
// ---------------------------------------------------------------------------
module rgb_linear_gradient_fill #(
    parameter int PIXEL_COUNT = rlgf_pkg::PIXEL_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // start_index, start_red, start_green, start_blue,
    // end_index, end_red, end_green, end_blue, zero pad
    input  logic [rlgf_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_index, red, green, blue, zero pad
    output logic [rlgf_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);

    localparam int IDX_W  = rlgf_pkg::IDX_W;
    localparam int COL_W  = rlgf_pkg::COL_W;
    localparam int ACC_W  = rlgf_pkg::ACC_W;
    localparam int NCH    = rlgf_pkg::NUM_CH;
    localparam int DSTEPS = rlgf_pkg::DIV_STEPS;
    localparam int CNT_W  = $clog2(DSTEPS);
    localparam int CH_W   = $clog2(NCH);
    localparam int PAD_W  = rlgf_pkg::OUT_DATA_W - IDX_W - NCH * COL_W;
    localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(PIXEL_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DSTEPS - 1);
    localparam logic [CH_W-1:0]  CH_LAST  = CH_W'(NCH - 1);

    rlgf_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]  sp_reg, ep_reg, pix_reg, div_reg;
    logic [COL_W-1:0]  sc_reg [NCH];
    logic [COL_W-1:0]  ec_reg [NCH];
    logic [ACC_W-1:0]  acc_reg [NCH];
    logic [ACC_W-1:0]  step_reg [NCH];
    logic [CH_W-1:0]   ch_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DSTEPS-1:0] dq_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic              neg_reg;
    logic              m_tvalid_reg;
    logic [rlgf_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;

    // input unpacking and clamping
    logic [IDX_W-1:0] in_sp_raw, in_ep_raw, in_sp, in_ep;
    logic [COL_W-1:0] in_sc [NCH];
    logic [COL_W-1:0] in_ec [NCH];
    logic             in_swap;
    logic [IDX_W-1:0] lo_idx, hi_idx, span;

    always_comb
    begin
        in_sp_raw = s_tdata[IDX_W-1:0];
        in_ep_raw = s_tdata[IDX_W+NCH*COL_W +: IDX_W];
        for (int c = 0; c < NCH; c++)
        begin
            in_sc[c] = s_tdata[IDX_W + c*COL_W +: COL_W];
            in_ec[c] = s_tdata[2*IDX_W + (NCH+c)*COL_W +: COL_W];
        end
        in_sp   = (in_sp_raw > IDX_MAX) ? IDX_MAX : in_sp_raw;
        in_ep   = (in_ep_raw > IDX_MAX) ? IDX_MAX : in_ep_raw;
        in_swap = in_ep < in_sp;
        lo_idx  = in_swap ? in_ep : in_sp;
        hi_idx  = in_swap ? in_sp : in_ep;
        span    = hi_idx - lo_idx;
    end

    // channel load: magnitude of (end - start) << 7 and its sign
    logic [COL_W:0]    diff;
    logic [COL_W-1:0]  mag;
    always_comb
    begin
        diff = {1'b0, ec_reg[ch_reg]} - {1'b0, sc_reg[ch_reg]};
        mag  = diff[COL_W] ? (~diff[COL_W-1:0] + COL_W'(1)) : diff[COL_W-1:0];
    end

    // one restoring divide step
    logic [IDX_W:0]    rem_shift, rem_sub;
    logic              rem_ge;
    logic [IDX_W-1:0]  rem_step;
    logic [DSTEPS-1:0] dq_step;
    logic [ACC_W-1:0]  q2, step_val;
    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[DSTEPS-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        rem_ge    = rem_shift >= {1'b0, div_reg};
        rem_step  = rem_ge ? rem_sub[IDX_W-1:0] : rem_shift[IDX_W-1:0];
        dq_step   = {dq_reg[DSTEPS-2:0], rem_ge};
        q2        = ACC_W'({dq_step, 1'b0});
        step_val  = neg_reg ? (~q2 + ACC_W'(1)) : q2;
    end

    // sequencer: next state
    logic in_fire, emit_fire, div_last, pix_last;
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rlgf_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = rlgf_pkg::ST_LOAD;
            end
            rlgf_pkg::ST_LOAD:
                state_next = rlgf_pkg::ST_DIV;
            rlgf_pkg::ST_DIV:
            begin
                if (div_last)
                    state_next = (ch_reg == CH_LAST) ? rlgf_pkg::ST_EMIT : rlgf_pkg::ST_LOAD;
            end
            rlgf_pkg::ST_EMIT:
            begin
                if (emit_fire && pix_last)
                    state_next = rlgf_pkg::ST_IDLE;
            end
            default:
                state_next = rlgf_pkg::ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        s_tready  = 1'b0;
        emit_fire = 1'b0;
        div_last  = 1'b0;
        pix_last  = pix_reg == ep_reg;
        unique case (state_reg)
            rlgf_pkg::ST_IDLE:
                s_tready = 1'b1;
            rlgf_pkg::ST_LOAD:
                ;
            rlgf_pkg::ST_DIV:
                div_last = cnt_reg == CNT_LAST;
            rlgf_pkg::ST_EMIT:
                emit_fire = !m_tvalid_reg || m_tready;
            default:
                ;
        endcase
        in_fire = s_tvalid && s_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rlgf_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            ch_reg       <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (in_fire)
                ch_reg <= '0;
            else if (div_last)
                ch_reg <= ch_reg + CH_W'(1);
            if (state_reg == rlgf_pkg::ST_LOAD)
                cnt_reg <= '0;
            else if (state_reg == rlgf_pkg::ST_DIV)
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sp_reg  <= lo_idx;
            ep_reg  <= hi_idx;
            pix_reg <= lo_idx;
            div_reg <= (span == '0) ? IDX_W'(1) : span;
            for (int c = 0; c < NCH; c++)
            begin
                sc_reg[c]  <= in_swap ? in_ec[c] : in_sc[c];
                ec_reg[c]  <= in_swap ? in_sc[c] : in_ec[c];
                acc_reg[c] <= {(in_swap ? in_ec[c] : in_sc[c]), {(ACC_W-COL_W){1'b0}}};
            end
        end
        if (state_reg == rlgf_pkg::ST_LOAD)
        begin
            dq_reg  <= {mag, {rlgf_pkg::FRAC_SHIFT{1'b0}}};
            rem_reg <= '0;
            neg_reg <= diff[COL_W];
        end
        if (state_reg == rlgf_pkg::ST_DIV)
        begin
            dq_reg  <= dq_step;
            rem_reg <= rem_step;
            if (div_last)
                step_reg[ch_reg] <= step_val;
        end
        if (emit_fire)
        begin
            m_tdata_reg <= {{PAD_W{1'b0}}, acc_reg[2][ACC_W-1 -: COL_W],
                            acc_reg[1][ACC_W-1 -: COL_W], acc_reg[0][ACC_W-1 -: COL_W],
                            pix_reg};
            m_tlast_reg <= pix_last;
            pix_reg     <= pix_reg + IDX_W'(1);
            for (int c = 0; c < NCH; c++)
                acc_reg[c] <= acc_reg[c] + step_reg[c];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == rlgf_pkg::ST_LOAD) && (ch_reg == '0))
        else $error("accept did not start channel load");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlgf_pkg::ST_DIV) |-> (cnt_reg <= CNT_LAST))
        else $error("divider step count overran");

    a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlgf_pkg::ST_EMIT) |-> (pix_reg >= sp_reg) && (pix_reg <= ep_reg))
        else $error("pixel index left the run");

    a_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlgf_pkg::ST_DIV) |-> (div_reg != '0))
        else $error("zero divisor in divider");

endmodule

// File: sim/rgb_linear_gradient_fill_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb_linear_gradient_fill_checker: gradient fill scoreboard
// Watches both stream channels. Expands each accepted pair of ends into the
// pixel run the block should emit, then compares every output transfer
// field by field against the oldest pending pixel.
// ---------------------------------------------------------------------------
module rgb_linear_gradient_fill_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [rlgf_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rlgf_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             m_tlast,
    output int                               mismatches,
    output int                               pixels_outstanding,
    output int                               pixels_checked,
    output int                               gradients_taken
);

    typedef struct packed {
        logic [rlgf_pkg::IDX_W-1:0] index;
        logic [rlgf_pkg::COL_W-1:0] red;
        logic [rlgf_pkg::COL_W-1:0] green;
        logic [rlgf_pkg::COL_W-1:0] blue;
        logic                       last;
    } pixel_t;

    pixel_t expected_pixels[$];

    initial
    begin
        mismatches         = 0;
        pixels_outstanding = 0;
        pixels_checked     = 0;
        gradients_taken    = 0;
    end

    // Sort the ends, work out the signed 8.7 step per channel, then walk the
    // 8.8 accumulators across the run.
    function automatic void predict_gradient(input logic [rlgf_pkg::IN_DATA_W-1:0] ends);
        logic [rlgf_pkg::IDX_W-1:0] lo_idx;
        logic [rlgf_pkg::IDX_W-1:0] hi_idx;
        logic [rlgf_pkg::COL_W-1:0] lo_col [rlgf_pkg::NUM_CH];
        logic [rlgf_pkg::COL_W-1:0] hi_col [rlgf_pkg::NUM_CH];
        logic [rlgf_pkg::ACC_W-1:0] acc    [rlgf_pkg::NUM_CH];
        logic [rlgf_pkg::ACC_W-1:0] step   [rlgf_pkg::NUM_CH];
        pixel_t px;
        int divisor;
        int col_dist;
        int quo;

        lo_idx = ends[5:0];
        hi_idx = ends[35:30];
        for (int c = 0; c < rlgf_pkg::NUM_CH; c++)
        begin
            lo_col[c] = ends[6 + 8*c +: 8];
            hi_col[c] = ends[36 + 8*c +: 8];
        end
        if (hi_idx < lo_idx)
        begin
            {lo_idx, hi_idx} = {hi_idx, lo_idx};
            for (int c = 0; c < rlgf_pkg::NUM_CH; c++)
                {lo_col[c], hi_col[c]} = {hi_col[c], lo_col[c]};
        end

        divisor = (hi_idx == lo_idx) ? 1 : int'(hi_idx) - int'(lo_idx);
        for (int c = 0; c < rlgf_pkg::NUM_CH; c++)
        begin
            col_dist = (int'(hi_col[c]) - int'(lo_col[c])) * 128;
            quo      = col_dist / divisor;        // truncates toward zero
            step[c]  = 16'(quo * 2);
            acc[c]   = {lo_col[c], 8'h00};
        end

        for (int i = int'(lo_idx); i <= int'(hi_idx); i++)
        begin
            px.index = i[5:0];
            px.red   = acc[0][15:8];
            px.green = acc[1][15:8];
            px.blue  = acc[2][15:8];
            px.last  = (i == int'(hi_idx));
            expected_pixels.push_back(px);
            for (int c = 0; c < rlgf_pkg::NUM_CH; c++)
                acc[c] = acc[c] + step[c];
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        pixel_t want;

        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_gradient(s_tdata);
                gradients_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected pixel transfer, expected none, got %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_index", want.index, m_tdata[5:0]);
                    check_field("red",         want.red,   m_tdata[13:6]);
                    check_field("green",       want.green, m_tdata[21:14]);
                    check_field("blue",        want.blue,  m_tdata[29:22]);
                    check_field("last_pixel",  want.last,  m_tlast);
                    pixels_checked++;
                end
            end
            pixels_outstanding = expected_pixels.size();
        end
    end

endmodule

// File: sim/rgb_linear_gradient_fill_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb_linear_gradient_fill_tb: gradient fill testbench
// Sends directed pairs of ends, then random pairs through four handshake phases,
// including one long output hold-off, and lets the checker score the pixels.
// ---------------------------------------------------------------------------
module rgb_linear_gradient_fill_tb;

    localparam int ITEMS_PER_PHASE = 110;
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 5000;
    localparam int TAIL_CYCLES     = 150;

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [rlgf_pkg::IN_DATA_W-1:0]   s_tdata  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [rlgf_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                             m_tlast;

    int mismatches;
    int pixels_outstanding;
    int pixels_checked;
    int gradients_taken;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit hold_armed     = 1'b0;
    int hold_count     = 0;
    int quiet_cycles   = 0;
    int directed_count = 0;

    rgb_linear_gradient_fill u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rgb_linear_gradient_fill_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tlast            (m_tlast),
        .mismatches         (mismatches),
        .pixels_outstanding (pixels_outstanding),
        .pixels_checked     (pixels_checked),
        .gradients_taken    (gradients_taken)
    );

    always #10 clk = ~clk;

    // Output side: one long hold-off once armed, random stalls otherwise.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_armed && hold_count < HOLD_CYCLES)
        begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("rgb_linear_gradient_fill_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic send_ends(input logic [5:0] si, input logic [7:0] sr, input logic [7:0] sg,
                             input logic [7:0] sb, input logic [5:0] ei, input logic [7:0] er,
                             input logic [7:0] eg, input logic [7:0] eb);
        bit taken;

        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, eb, eg, er, ei, sb, sg, sr, si};
        // s_tready is settled by mid-cycle; the transfer happens on the next edge
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Mostly short runs, some medium, a few close to the full strip.
    task automatic send_random();
        int sel;
        int len;
        int lo;
        logic [5:0] a;
        logic [5:0] b;
        logic [7:0] col [6];

        sel = $urandom_range(0, 99);
        if (sel < 70)
            len = $urandom_range(0, 12);
        else if (sel < 95)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(41, 63);
        lo = $urandom_range(0, 63 - len);
        a  = lo[5:0];
        b  = 6'(lo + len);
        if ($urandom_range(0, 1))
            {a, b} = {b, a};
        for (int k = 0; k < 6; k++)
        begin
            case ($urandom_range(0, 9))
                0:       col[k] = 8'h00;
                1:       col[k] = 8'hFF;
                default: col[k] = 8'($urandom_range(0, 255));
            endcase
        end
        send_ends(a, col[0], col[1], col[2], b, col[3], col[4], col[5]);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: equal ends, full strip both ways, reversed ends, rounding
        send_ends(6'd0,  8'h00, 8'h00, 8'h00, 6'd0,  8'hFF, 8'hFF, 8'hFF);
        send_ends(6'd63, 8'hFF, 8'hFF, 8'hFF, 6'd63, 8'h00, 8'h00, 8'h00);
        send_ends(6'd32, 8'h5A, 8'hA5, 8'h3C, 6'd32, 8'h12, 8'h34, 8'h56);
        send_ends(6'd0,  8'h00, 8'h00, 8'h00, 6'd63, 8'hFF, 8'hFF, 8'hFF);
        send_ends(6'd0,  8'hFF, 8'hFF, 8'hFF, 6'd63, 8'h00, 8'h00, 8'h00);
        send_ends(6'd63, 8'h00, 8'hFF, 8'h80, 6'd0,  8'hFF, 8'h00, 8'h7F);
        send_ends(6'd10, 8'h00, 8'hFF, 8'h01, 6'd11, 8'hFF, 8'h00, 8'hFE);
        send_ends(6'd0,  8'd100, 8'd0, 8'd255, 6'd63, 8'd101, 8'd1, 8'd254);
        send_ends(6'd5,  8'd101, 8'd1, 8'd254, 6'd8,  8'd100, 8'd0, 8'd255);
        send_ends(6'd20, 8'h10, 8'hC0, 8'h77, 6'd5,  8'hF0, 8'h20, 8'h88);
        send_ends(6'd1,  8'hFF, 8'h80, 8'h00, 6'd0,  8'h00, 8'h7F, 8'hFF);
        send_ends(6'd62, 8'h01, 8'h02, 8'h03, 6'd63, 8'hFD, 8'hFE, 8'hFF);
        send_ends(6'd7,  8'hAA, 8'h55, 8'hAA, 6'd0,  8'h55, 8'hAA, 8'h55);
        send_ends(6'd0,  8'h55, 8'hAA, 8'h55, 6'd63, 8'hAA, 8'h55, 8'hAA);
        send_ends(6'd42, 8'd3,  8'd250, 8'd128, 6'd21, 8'd250, 8'd3, 8'd127);
        directed_count = 15;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  hold_armed = 1'b1; end
                1:       begin src_idle_pct = 52; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin src_idle_pct = 19; sink_stall_pct = 19; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        wait (pixels_outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d gradients (%0d directed, %0d random) and %0d pixels,",
                 gradients_taken, directed_count, gradients_taken - directed_count,
                 pixels_checked);
        $display("over free-running, sender-idle, receiver-stall and mixed phases plus a long hold-off.");
        if (mismatches == 0 && pixels_outstanding == 0)
            $display("rgb_linear_gradient_fill_tb OK");
        else
            $display("rgb_linear_gradient_fill_tb NOT OK");
        $finish;
    end

endmodule
